@@ rtl/core/fdfp_pkg.sv @@
package fdfp_pkg;

    // Frame framing bytes
    localparam logic [7:0] SYNC_FIRST    = 8'h05;
    localparam logic [7:0] SYNC_SECOND   = 8'h02;
    localparam logic [7:0] LEN_CHECK     = 8'hFF;
    localparam logic [7:0] TYPE_PRIMARY  = 8'h01;
    localparam logic [7:0] TYPE_ATTITUDE = 8'h03;

    // Byte positions of the frame header
    localparam logic [8:0] POS_HUNT    = 9'd0;
    localparam logic [8:0] POS_SYNC_B  = 9'd1;
    localparam logic [8:0] POS_LEN     = 9'd2;
    localparam logic [8:0] POS_LEN_INV = 9'd3;
    localparam logic [8:0] POS_BODY    = 9'd4;

    localparam logic [8:0] LEN_ZERO_AS  = 9'd256;
    localparam logic [8:0] LEN_EXTRA    = 9'd20;
    localparam logic [8:0] PRIMARY_LEN  = 9'd44;
    localparam logic [8:0] ATTITUDE_LEN = 9'd40;

    localparam logic [7:0] HOUR_MAX   = 8'd23;
    localparam logic [7:0] MINSEC_MAX = 8'd59;

    // Only bytes up to the time fields are ever decoded
    localparam int STORE_DEPTH = 35;
    localparam int STORE_AW    = 6;

    localparam logic KIND_PRIMARY  = 1'b0;
    localparam logic KIND_ATTITUDE = 1'b1;

    // Q.16 scale factors with SCALE_FRAC fraction bits, truncated
    localparam int SCALE_FRAC = 34;
    // 0.05399565 * 65536 = 276457728 / 78125
    localparam logic [47:0] COEF_KNOT =
        48'((64'd276457728 << SCALE_FRAC) / 64'd78125);
    // 0.1 * 65536 = 32768 / 5
    localparam logic [47:0] COEF_TENTH =
        48'((64'd1 << (SCALE_FRAC + 15)) / 64'd5);
    // 0.01 * 65536 = 16384 / 25
    localparam logic [47:0] COEF_HUNDREDTH =
        48'((64'd1 << (SCALE_FRAC + 14)) / 64'd25);

    typedef struct packed {
        logic        kind;
        logic [15:0] w_a;
        logic [15:0] w_b;
        logic [31:0] w_c;
        logic [15:0] w_d;
        logic [15:0] w_e;
        logic [15:0] w_f;
        logic        time_ok;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_raw;

    typedef struct packed {
        logic done;
        t_raw raw;
    } t_frame_evt;

    // round(word * coef / 2^SCALE_FRAC), symmetric about zero, 48-bit result
    function automatic logic [47:0] q16_scale(input logic [15:0] word,
                                              input logic        is_signed,
                                              input logic [47:0] coef);
        logic        neg;
        logic [16:0] sx;
        logic [16:0] mag;
        logic [64:0] prod;
        logic [47:0] q;
        neg  = is_signed & word[15];
        sx   = {neg, word};
        mag  = neg ? (~sx + 17'd1) : sx;
        prod = 65'(mag) * 65'(coef) + (65'd1 << (SCALE_FRAC - 1));
        q    = {17'd0, prod[SCALE_FRAC+30:SCALE_FRAC]};
        return neg ? (~q + 48'd1) : q;
    endfunction

    function automatic logic [47:0] q16_int16(input logic [15:0] word);
        return {{16{word[15]}}, word, 16'h0000};
    endfunction

endpackage

@@ rtl/core/flight_data_frame_parser_unit.sv @@
// Channel  | Direction | Handshake                  | Payload
// rx byte  | in        | i_in_valid / o_in_stall    | i_rx_byte
// frame    | out       | o_out_valid / i_out_stall  | o_frame_kind .. o_second
//
// One byte is taken per cycle while o_in_stall is low. A frame result passes from its
// final byte through the field capture register, then through the constant
// multipliers into the output register.
// Reset (synchronous, active low) drops any partial frame and empties both stages.
// A stalled output holds; the input stalls only once both stages are full.
module flight_data_frame_parser_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [7:0]   i_rx_byte,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic         o_frame_kind,
    output logic [47:0]  o_value_a,
    output logic [47:0]  o_value_b,
    output logic [47:0]  o_value_c,
    output logic [47:0]  o_value_d,
    output logic [47:0]  o_value_e,
    output logic [47:0]  o_value_f,
    output logic         o_time_valid,
    output logic [4:0]   o_hour,
    output logic [5:0]   o_minute,
    output logic [5:0]   o_second
);
    import fdfp_pkg::*;

    t_frame_evt evt;
    t_raw       r_cap;
    logic       r_cap_vld;
    logic       r_out_vld;
    logic       out_adv;
    logic       cap_free;
    logic       take;

    logic        r_kind;
    logic [47:0] r_value_a, r_value_b, r_value_c, r_value_d, r_value_e, r_value_f;
    logic        r_time_valid;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute, r_second;

    logic [47:0] n_value_a, n_value_b, n_value_c, n_value_d, n_value_e, n_value_f;

    // Advance the output when empty or taken; the capture stage follows it
    assign out_adv  = !r_out_vld || !i_out_stall;
    assign cap_free = !r_cap_vld || out_adv;
    assign take     = i_in_valid && cap_free;

    assign o_in_stall = !cap_free;

    fdfp_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_rx_byte),
        .o_evt     (evt)
    );

    // Capture stage: hold the raw fields of a completed frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_vld <= 1'b0;
        end else if (cap_free) begin
            r_cap_vld <= take && evt.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cap_free) begin
            r_cap <= evt.raw;
        end
    end

    // Scale stage: constant multiplies for the values that need scaling, coefficient chosen by kind
    always_comb begin
        if (r_cap.kind == KIND_ATTITUDE) begin
            n_value_a = q16_scale(r_cap.w_a, 1'b0, COEF_TENTH);
            n_value_b = q16_scale(r_cap.w_b, 1'b1, COEF_TENTH);
            n_value_c = q16_scale(r_cap.w_c[15:0], 1'b1, COEF_TENTH);
            n_value_d = q16_scale(r_cap.w_d, 1'b1, COEF_HUNDREDTH);
            n_value_e = q16_scale(r_cap.w_e, 1'b1, COEF_HUNDREDTH);
            n_value_f = 48'd0;
        end else begin
            n_value_a = q16_scale(r_cap.w_a, 1'b0, COEF_KNOT);
            n_value_b = q16_scale(r_cap.w_b, 1'b0, COEF_KNOT);
            n_value_c = {r_cap.w_c, 16'h0000};
            n_value_d = q16_int16(r_cap.w_d);
            n_value_e = q16_int16(r_cap.w_e);
            n_value_f = q16_int16(r_cap.w_f);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_cap_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_cap_vld) begin
            r_kind       <= r_cap.kind;
            r_value_a    <= n_value_a;
            r_value_b    <= n_value_b;
            r_value_c    <= n_value_c;
            r_value_d    <= n_value_d;
            r_value_e    <= n_value_e;
            r_value_f    <= n_value_f;
            r_time_valid <= r_cap.time_ok;
            r_hour       <= r_cap.hour;
            r_minute     <= r_cap.minute;
            r_second     <= r_cap.second;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_frame_kind = r_kind;
    assign o_value_a    = r_value_a;
    assign o_value_b    = r_value_b;
    assign o_value_c    = r_value_c;
    assign o_value_d    = r_value_d;
    assign o_value_e    = r_value_e;
    assign o_value_f    = r_value_f;
    assign o_time_valid = r_time_valid;
    assign o_hour       = r_hour;
    assign o_minute     = r_minute;
    assign o_second     = r_second;

endmodule

@@ rtl/core/fdfp_framer.sv @@
module fdfp_framer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_rx_byte,
    output fdfp_pkg::t_frame_evt o_evt
);
    import fdfp_pkg::*;

    logic [8:0] r_count, n_count;
    logic [8:0] r_len, n_len;
    logic [7:0] r_store [STORE_DEPTH];

    logic [8:0] count_inc;
    logic [8:0] len_dec;
    logic       last;
    logic       is_pri;
    logic       is_att;
    logic       time_ok;

    // Header hunt and body count
    always_comb begin
        n_count   = r_count;
        n_len     = r_len;
        count_inc = r_count + 9'd1;
        len_dec   = (r_store[2] == 8'h00) ? LEN_ZERO_AS : {1'b0, r_store[2]};
        last      = 1'b0;
        if (i_take) begin
            if (r_count == POS_HUNT) begin
                if (i_rx_byte == SYNC_FIRST) n_count = POS_SYNC_B;
            end else if (r_count == POS_SYNC_B) begin
                n_count = (i_rx_byte == SYNC_SECOND) ? POS_LEN : POS_HUNT;
            end else if (r_count == POS_LEN) begin
                n_count = POS_LEN_INV;
            end else if (r_count == POS_LEN_INV) begin
                if ((r_store[2] ^ i_rx_byte) == LEN_CHECK) begin
                    n_count = POS_BODY;
                    n_len   = len_dec + LEN_EXTRA;
                end else begin
                    n_count = POS_HUNT;
                end
            end else if (count_inc == r_len) begin
                n_count = POS_HUNT;
                last    = 1'b1;
            end else begin
                n_count = count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= POS_HUNT;
            r_len   <= 9'd0;
        end else begin
            r_count <= n_count;
            r_len   <= n_len;
        end
    end

    // Keep the low bytes of the frame; later ones are never decoded
    always_ff @(posedge i_clk) begin
        if (i_take && (r_count < 9'(STORE_DEPTH))) begin
            r_store[r_count[STORE_AW-1:0]] <= i_rx_byte;
        end
    end

    // Pick out the fields; the final byte of a good frame is never a field
    always_comb begin
        is_pri  = (r_store[4] == TYPE_PRIMARY) && (r_len == PRIMARY_LEN);
        is_att  = (r_store[4] == TYPE_ATTITUDE) && (r_len == ATTITUDE_LEN);
        time_ok = is_pri && (r_store[32] <= HOUR_MAX) && (r_store[33] <= MINSEC_MAX)
                  && (r_store[34] <= MINSEC_MAX);

        o_evt.done     = last && (is_pri || is_att);
        o_evt.raw.kind = is_att ? KIND_ATTITUDE : KIND_PRIMARY;
        if (is_att) begin
            o_evt.raw.w_a = {r_store[9], r_store[8]};
            o_evt.raw.w_b = {r_store[11], r_store[10]};
            o_evt.raw.w_c = {16'h0000, r_store[13], r_store[12]};
            o_evt.raw.w_f = 16'h0000;
        end else begin
            o_evt.raw.w_a = {r_store[17], r_store[16]};
            o_evt.raw.w_b = {r_store[19], r_store[18]};
            o_evt.raw.w_c = {r_store[11], r_store[10], r_store[9], r_store[8]};
            o_evt.raw.w_f = {r_store[29], r_store[28]};
        end
        o_evt.raw.w_d     = {r_store[21], r_store[20]};
        o_evt.raw.w_e     = {r_store[23], r_store[22]};
        o_evt.raw.time_ok = time_ok;
        o_evt.raw.hour    = time_ok ? r_store[32][4:0] : 5'd0;
        o_evt.raw.minute  = time_ok ? r_store[33][5:0] : 6'd0;
        o_evt.raw.second  = time_ok ? r_store[34][5:0] : 6'd0;
    end

endmodule

@@ rtl/core/fdfp_checker.sv @@
module fdfp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_out_valid,
    input logic         i_out_stall,
    input logic         o_frame_kind,
    input logic [47:0]  o_value_a,
    input logic [47:0]  o_value_f,
    input logic         o_time_valid,
    input logic [4:0]   o_hour,
    input logic [5:0]   o_minute,
    input logic [5:0]   o_second
);
    import fdfp_pkg::*;

    // A stalled transfer holds its kind and value_a
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value_a)
            && $stable(o_frame_kind))
        else $error("output transfer changed under stall");

    // Attitude frames carry no time and no temperature
    a_att_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_frame_kind == KIND_ATTITUDE) |-> !o_time_valid
            && (o_value_f == 48'd0))
        else $error("attitude frame carries time or temperature");

    // Invalid time reads as zero
    a_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_time_valid |-> (o_hour == 5'd0) && (o_minute == 6'd0)
            && (o_second == 6'd0))
        else $error("time fields set without valid time");

    // Valid time lies in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_time_valid |-> (o_hour <= 5'd23) && (o_minute <= 6'd59)
            && (o_second <= 6'd59))
        else $error("valid time out of range");

endmodule

bind flight_data_frame_parser_unit fdfp_checker u_fdfp_checker (.*);

@@ dv/tb_top.sv @@
module tb_top;

    import fdfp_pkg::*;

    // Length bytes of the two frames that decode: total length less the fixed overhead
    localparam logic [7:0] L_PRIMARY  = 8'(PRIMARY_LEN - LEN_EXTRA);
    localparam logic [7:0] L_ATTITUDE = 8'(ATTITUDE_LEN - LEN_EXTRA);

    // Exact scale ratios of the decoded values
    localparam longint unsigned KNOT_MUL = 64'd5399565;
    localparam longint unsigned KNOT_DIV = 64'd100000000;
    localparam longint unsigned TENTH    = 64'd10;
    localparam longint unsigned HUNDREDTH = 64'd100;

    localparam int unsigned BUF_BYTES  = 64;
    localparam int unsigned LONG_HOLD  = 400;
    localparam int unsigned MIN_BYTES  = 2000;

    typedef struct packed {
        logic        kind;
        logic [47:0] val_a;
        logic [47:0] val_b;
        logic [47:0] val_c;
        logic [47:0] val_d;
        logic [47:0] val_e;
        logic [47:0] val_f;
        logic        time_ok;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } frame_res_t;

    // Byte-level frame decoder mirrored in the testbench, plus the queue of decoded
    // frames still owed by the block.
    class frame_scoreboard;
        frame_res_t  pending_q[$];
        int unsigned mismatches;
        int unsigned taken;
        int unsigned frame_len;
        bit [7:0]    store [BUF_BYTES];

        function bit [15:0] word16(int unsigned pos);
            return {store[pos + 1], store[pos]};
        endfunction

        // round(x * mul / div) in Q.16, ties away from zero, 48-bit two's complement
        function bit [47:0] round_q16(longint x, longint unsigned mul,
                                      longint unsigned div);
            longint unsigned mag;
            longint unsigned q;
            bit [63:0]       r;
            mag = (x < 0) ? -x : x;
            q   = (mag * mul * 64'd65536 + div / 2) / div;
            r   = (x < 0) ? -q : q;
            return r[47:0];
        endfunction

        function void note_byte(bit [7:0] b);
            frame_res_t r;
            r = '0;
            if (taken == 0) begin
                if (b == SYNC_FIRST) begin
                    store[0] = b;
                    taken = 1;
                end
            end else if (taken == 1) begin
                // a bad second sync byte is not retried as a first one
                if (b == SYNC_SECOND) begin
                    store[1] = b;
                    taken = 2;
                end else begin
                    taken = 0;
                end
            end else if (taken < 4) begin
                store[taken] = b;
                taken++;
                if (taken == 4) begin
                    if ((store[2] ^ store[3]) != LEN_CHECK) begin
                        taken = 0;
                    end else begin
                        frame_len = ((store[2] == 8'd0) ? int'(LEN_ZERO_AS) : int'(store[2]))
                                    + int'(LEN_EXTRA);
                    end
                end
            end else begin
                if (taken < frame_len) begin
                    if (taken < BUF_BYTES) store[taken] = b;
                    taken++;
                end
                if (taken >= frame_len) begin
                    if (store[4] == TYPE_PRIMARY && taken == PRIMARY_LEN) begin
                        r.kind  = KIND_PRIMARY;
                        r.val_a = round_q16(longint'(word16(16)), KNOT_MUL, KNOT_DIV);
                        r.val_b = round_q16(longint'(word16(18)), KNOT_MUL, KNOT_DIV);
                        r.val_c = round_q16(longint'($signed({word16(10), word16(8)})), 1, 1);
                        r.val_d = round_q16(longint'($signed(word16(20))), 1, 1);
                        r.val_e = round_q16(longint'($signed(word16(22))), 1, 1);
                        r.val_f = round_q16(longint'($signed(word16(28))), 1, 1);
                        if (store[32] <= HOUR_MAX && store[33] <= MINSEC_MAX &&
                            store[34] <= MINSEC_MAX) begin
                            r.time_ok = 1'b1;
                            r.hour    = store[32][4:0];
                            r.minute  = store[33][5:0];
                            r.second  = store[34][5:0];
                        end
                        pending_q.push_back(r);
                    end else if (store[4] == TYPE_ATTITUDE && taken == ATTITUDE_LEN) begin
                        r.kind  = KIND_ATTITUDE;
                        r.val_a = round_q16(longint'(word16(8)), 1, TENTH);
                        r.val_b = round_q16(longint'($signed(word16(10))), 1, TENTH);
                        r.val_c = round_q16(longint'($signed(word16(12))), 1, TENTH);
                        r.val_d = round_q16(longint'($signed(word16(20))), 1, HUNDREDTH);
                        r.val_e = round_q16(longint'($signed(word16(22))), 1, HUNDREDTH);
                        pending_q.push_back(r);
                    end
                    taken = 0;
                end
            end
        endfunction

        function void cmp(string field, logic [47:0] want, logic [47:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h, got %h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_frame(frame_res_t got);
            frame_res_t want;
            if (pending_q.size() == 0) begin
                $display("%0t: frame expected none, got kind %0d a %h b %h c %h",
                         $time, got.kind, got.val_a, got.val_b, got.val_c);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            cmp("frame_kind", 48'(want.kind), 48'(got.kind));
            cmp("value_a", want.val_a, got.val_a);
            cmp("value_b", want.val_b, got.val_b);
            cmp("value_c", want.val_c, got.val_c);
            cmp("value_d", want.val_d, got.val_d);
            cmp("value_e", want.val_e, got.val_e);
            cmp("value_f", want.val_f, got.val_f);
            cmp("time_valid", 48'(want.time_ok), 48'(got.time_ok));
            cmp("hour", 48'(want.hour), 48'(got.hour));
            cmp("minute", 48'(want.minute), 48'(got.minute));
            cmp("second", 48'(want.second), 48'(got.second));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_frame_kind;
    logic [47:0] o_value_a;
    logic [47:0] o_value_b;
    logic [47:0] o_value_c;
    logic [47:0] o_value_d;
    logic [47:0] o_value_e;
    logic [47:0] o_value_f;
    logic        o_time_valid;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;

    frame_scoreboard sb = new;
    frame_res_t      seen;

    // Frame under construction, and the idling controls shared by the processes
    bit [7:0]    frame_q[$];
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    bit          rx_hold_req = 1'b0;
    int unsigned bytes_sent = 0;

    always #1 i_clk = ~i_clk;

    flight_data_frame_parser_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_frame_kind (o_frame_kind),
        .o_value_a    (o_value_a),
        .o_value_b    (o_value_b),
        .o_value_c    (o_value_c),
        .o_value_d    (o_value_d),
        .o_value_e    (o_value_e),
        .o_value_f    (o_value_f),
        .o_time_valid (o_time_valid),
        .o_hour       (o_hour),
        .o_minute     (o_minute),
        .o_second     (o_second)
    );

    // Open a frame: sync pair, length and its complement, type, then random body.
    // Time bytes land mostly in range so that valid times are common.
    function automatic void start_frame(bit [7:0] len_byte, bit [7:0] type_byte);
        int unsigned total;
        total = ((len_byte == 8'd0) ? int'(LEN_ZERO_AS) : int'(len_byte)) + int'(LEN_EXTRA);
        frame_q = {};
        frame_q.push_back(SYNC_FIRST);
        frame_q.push_back(SYNC_SECOND);
        frame_q.push_back(len_byte);
        frame_q.push_back(~len_byte);
        frame_q.push_back(type_byte);
        while (frame_q.size() < total) frame_q.push_back(8'($urandom));
        if (total > 34 && $urandom_range(0, 5) != 0) begin
            frame_q[32] = 8'($urandom_range(0, 23));
            frame_q[33] = 8'($urandom_range(0, 59));
            frame_q[34] = 8'($urandom_range(0, 59));
        end
    endfunction

    function automatic void put16(int unsigned pos, bit [15:0] val);
        frame_q[pos]     = val[7:0];
        frame_q[pos + 1] = val[15:8];
    endfunction

    // Offer one byte after a drawn gap; hold it until the block takes the transfer.
    // Entered and left at a falling edge.
    task automatic send_byte(input bit [7:0] b);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_byte(b);
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i]);
        bytes_sent += frame_q.size();
    endtask

    task automatic send_primary(input bit [15:0] ias, input bit [15:0] tas,
                                input bit [31:0] alt, input bit [15:0] aoa,
                                input bit [15:0] vsi, input bit [15:0] oat,
                                input bit [7:0] hh, input bit [7:0] mi, input bit [7:0] ss);
        start_frame(L_PRIMARY, TYPE_PRIMARY);
        put16(8, alt[15:0]);
        put16(10, alt[31:16]);
        put16(16, ias);
        put16(18, tas);
        put16(20, aoa);
        put16(22, vsi);
        put16(28, oat);
        frame_q[32] = hh;
        frame_q[33] = mi;
        frame_q[34] = ss;
        send_frame();
    endtask

    task automatic send_attitude(input bit [15:0] hdg, input bit [15:0] pitch,
                                 input bit [15:0] roll, input bit [15:0] vert_g,
                                 input bit [15:0] lat_g);
        start_frame(L_ATTITUDE, TYPE_ATTITUDE);
        put16(8, hdg);
        put16(10, pitch);
        put16(12, roll);
        put16(20, vert_g);
        put16(22, lat_g);
        send_frame();
    endtask

    // Drop valid and wait for every owed frame, then let the pipeline settle
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Result monitor: check every output transfer against the oldest owed frame
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            seen.kind    = o_frame_kind;
            seen.val_a   = o_value_a;
            seen.val_b   = o_value_b;
            seen.val_c   = o_value_c;
            seen.val_d   = o_value_d;
            seen.val_e   = o_value_e;
            seen.val_f   = o_value_f;
            seen.time_ok = o_time_valid;
            seen.hour    = o_hour;
            seen.minute  = o_minute;
            seen.second  = o_second;
            sb.check_frame(seen);
        end
    end

    // Receiver: draw a stall length per frame, then release until a transfer lands.
    // A hold request from the stimulus turns the next draw into one long stretch.
    initial begin : receiver
        int unsigned hold_cycles;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            if (rx_hold_req) begin
                hold_cycles = LONG_HOLD;
                rx_hold_req = 1'b0;
            end else begin
                hold_cycles = rx_burst ? 0 : $urandom_range(0, 10);
            end
            if (hold_cycles != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int unsigned pick;
        int unsigned iter;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Hunting noise, then a bad second sync byte followed by a stray second sync
        frame_q = {8'h00, 8'hFF, SYNC_SECOND, SYNC_FIRST, SYNC_FIRST, SYNC_SECOND,
                   L_PRIMARY, ~L_PRIMARY, TYPE_PRIMARY};
        send_frame();

        // Primary frames at the field extremes and with each time field out of range
        send_primary(16'h0000, 16'hFFFF, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 16'hFFFF,
                     8'd23, 8'd59, 8'd59);
        send_primary(16'hFFFF, 16'h0000, 32'h8000_0000, 16'h7FFF, 16'h8000, 16'h8000,
                     8'd0, 8'd0, 8'd0);
        send_primary(16'h0001, 16'h0002, 32'hFFFF_FFFF, 16'hFFFF, 16'h0001, 16'h0000,
                     8'd24, 8'd0, 8'd0);
        send_primary(16'h1234, 16'h8000, 32'h0000_0000, 16'h0000, 16'hFFFF, 16'h7FFF,
                     8'd0, 8'd60, 8'd0);
        send_primary(16'h7FFF, 16'h0001, 32'h0001_0000, 16'h0001, 16'h0000, 16'h0001,
                     8'd0, 8'd0, 8'd60);
        send_primary(16'h8000, 16'h7FFF, 32'h00FF_FF00, 16'h4000, 16'hC000, 16'hFFF6,
                     8'd255, 8'd255, 8'd255);

        // Attitude frames at the extremes and around zero
        send_attitude(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_attitude(16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_attitude(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0005);

        // Bad length complement: back to hunting after the fourth byte
        frame_q = {SYNC_FIRST, SYNC_SECOND, L_PRIMARY, L_PRIMARY, TYPE_PRIMARY};
        send_frame();

        // Wrong type, and the right types at the wrong length: no result
        start_frame(L_PRIMARY, 8'h02);
        send_frame();
        start_frame(L_ATTITUDE, TYPE_PRIMARY);
        send_frame();
        start_frame(L_PRIMARY, TYPE_ATTITUDE);
        send_frame();

        // Shortest frame, and frames longer than the buffer (length zero means 256)
        start_frame(8'd1, TYPE_PRIMARY);
        send_frame();
        start_frame(8'd0, TYPE_PRIMARY);
        send_frame();
        start_frame(8'd255, TYPE_ATTITUDE);
        send_frame();
        send_attitude(16'd3600, 16'hFF9C, 16'd450, 16'd100, 16'hFFCE);

        hold_until_drained();

        // Random traffic: mostly well-formed frames with random content, the rest
        // noise, broken headers and odd lengths or types
        iter = 0;
        while (bytes_sent < MIN_BYTES) begin
            if ($urandom_range(0, 9) == 0) tx_burst = !tx_burst;
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                start_frame(L_PRIMARY, TYPE_PRIMARY);
            end else if (pick < 72) begin
                start_frame(L_ATTITUDE, TYPE_ATTITUDE);
            end else if (pick < 82) begin
                frame_q = {};
                repeat ($urandom_range(1, 8)) begin
                    frame_q.push_back(($urandom_range(0, 3) == 0) ? SYNC_FIRST
                                                                  : 8'($urandom));
                end
            end else if (pick < 90) begin
                // break either the second sync byte or the length complement
                start_frame(($urandom_range(0, 1) != 0) ? L_PRIMARY : L_ATTITUDE,
                            ($urandom_range(0, 1) != 0) ? TYPE_PRIMARY : TYPE_ATTITUDE);
                if ($urandom_range(0, 1) != 0)
                    frame_q[1] = SYNC_SECOND ^ 8'($urandom_range(1, 255));
                else
                    frame_q[3] = frame_q[3] ^ 8'($urandom_range(1, 255));
            end else if (pick < 98) begin
                start_frame(8'($urandom_range(1, 40)),
                            ($urandom_range(0, 2) == 0) ? TYPE_PRIMARY :
                            ($urandom_range(0, 1) == 0) ? TYPE_ATTITUDE : 8'($urandom));
            end else begin
                start_frame(8'($urandom_range(0, 255)), 8'($urandom));
            end
            send_frame();
            iter++;

            // Once: stall the receiver for a long stretch while frames keep coming
            // back to back, so both stages fill and the input stalls
            if (iter == 4) begin
                rx_hold_req = 1'b1;
                tx_burst    = 1'b1;
                repeat (12) begin
                    start_frame(L_ATTITUDE, TYPE_ATTITUDE);
                    send_frame();
                end
                hold_until_drained();
            end else if ($urandom_range(0, 59) == 0) begin
                hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/fdfp_pkg.sv
rtl/core/fdfp_framer.sv
rtl/core/flight_data_frame_parser_unit.sv
rtl/core/fdfp_checker.sv
dv/tb_top.sv
